/* sv/tsg_pkg.sv */
package tsg_pkg;

    // event kinds carried in req_type
    localparam logic [1:0] REQ_POLL    = 2'd0;
    localparam logic [1:0] REQ_TX      = 2'd1;
    localparam logic [1:0] REQ_RX      = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    // configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_GUARD  = 2'd0;
    localparam logic [1:0] REG_RESYNC = 2'd1;
    localparam logic [1:0] REG_PAD    = 2'd2;

    localparam int APB_AW = 4;
    localparam int CFG_W  = 16;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] GUARD_RST  = 16'd100;
    localparam logic [CFG_W-1:0] RESYNC_RST = 16'd10;
    localparam logic [CFG_W-1:0] PAD_RST    = 16'd10;

    // shared divider: 32-bit dividend, divisor up to 1023
    localparam int DIV_W      = 10;
    localparam int DIV_BITS   = 4;
    localparam logic [DIV_W-1:0] US_PER_MS = 10'd1000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] air_time_us;
    } in_t;

    typedef struct packed {
        logic        grant;
        logic        tx_pending;
        logic [31:0] avg_cycle_ms;
        logic [31:0] avg_air_ms;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [31:0]      dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

/* sv/transmit_slot_gate_top.sv */
// transmit slot gate
// Input channel s_valid/s_ready/s_data carries one event beat: poll, transmit
// request, reception (with airtime in us) or restart, each with a ms timestamp.
// Every event gives exactly one result beat on m_valid/m_ready/m_data: grant,
// pending flag and the current cycle and airtime averages.
// An APB port (paddr[3:2] selects guard, resync, airtime pad) sets the margins;
// write it only while the block is idle.
// Polls with a request pending pass through a re-anchor state and a grant
// decision state before the result register is loaded. A reception that
// records history divides air_time_us by 1000 and then, for each of the n
// stored entries (up to HISTORY_DEPTH), its gap and its airtime by n; all
// these divisions go through one shared divider that retires 4 quotient bits
// per cycle, and the history is read from one RAM port, one entry per pass.
// One event is in work at a time; s_ready is high only while the sequencer
// is idle. A finished result sits in the output register, and the sequencer
// waits before loading the next one if the receiver stalls, so nothing is lost.
// Reset (aresetn low, synchronous) clears pending, history count, timestamps
// and averages and restores the register defaults; history RAM is not cleared.
module transmit_slot_gate_top #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tsg_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tsg_pkg::out_t               m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsg_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tsg_pkg::*;

    localparam int IDX_W = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_POLL1  = 4'd2;
    localparam logic [3:0] S_POLL2  = 4'd3;
    localparam logic [3:0] S_AIRDIV = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_DG     = 4'd6;
    localparam logic [3:0] S_WG     = 4'd7;
    localparam logic [3:0] S_WA     = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]       state_reg, state_next;
    in_t              item_reg;
    logic [CFG_W-1:0] guard_reg, resync_reg, pad_reg;
    logic [31:0]      cycle_start_reg, cycle_start_next;
    logic [31:0]      last_rx_reg, last_rx_next;
    logic             pending_reg, pending_next;
    logic             started_reg, started_next;
    logic             grant_reg, grant_next;
    logic [IDX_W-1:0] wpos_reg, wpos_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [31:0]      avg_cyc_reg, avg_cyc_next;
    logic [31:0]      avg_air_reg, avg_air_next;
    logic [31:0]      acc_cyc_reg, acc_cyc_next;
    logic [31:0]      acc_air_reg, acc_air_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg;

    div_req_t         div_req;
    div_rsp_t         div_rsp;
    logic             ram_we, ram_re;
    logic [63:0]      ram_wdata, ram_rdata;

    logic             cfg_wr;
    logic [31:0]      elapsed;
    logic             s_fire;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign elapsed = item_reg.now_ms - cycle_start_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg  <= GUARD_RST;
            resync_reg <= RESYNC_RST;
            pad_reg    <= PAD_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_GUARD:  guard_reg  <= pwdata[CFG_W-1:0];
                REG_RESYNC: resync_reg <= pwdata[CFG_W-1:0];
                REG_PAD:    pad_reg    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GUARD:  prdata = {16'd0, guard_reg};
            REG_RESYNC: prdata = {16'd0, resync_reg};
            REG_PAD:    prdata = {16'd0, pad_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // shared divider and history memory
    tsg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    tsg_ram #(
        .WIDTH (64),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // upper half airtime, lower half gap
    assign ram_wdata = {32'(pad_reg) + div_rsp.quotient, elapsed};

    // sequencer
    always_comb begin
        state_next       = state_reg;
        cycle_start_next = cycle_start_reg;
        last_rx_next     = last_rx_reg;
        pending_next     = pending_reg;
        started_next     = started_reg;
        grant_next       = grant_reg;
        wpos_next        = wpos_reg;
        fill_next        = fill_reg;
        avg_cyc_next     = avg_cyc_reg;
        avg_air_next     = avg_air_reg;
        acc_cyc_next     = acc_cyc_reg;
        acc_air_next     = acc_air_reg;
        idx_next         = idx_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        div_req          = '0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                grant_next = 1'b0;
                state_next = S_DONE;
                case (item_reg.req_type)
                    REQ_POLL: begin
                        if (pending_reg) begin
                            state_next = S_POLL1;
                        end
                    end
                    REQ_TX: begin
                        pending_next = 1'b1;
                    end
                    REQ_RX: begin
                        if (!pending_reg) begin
                            if (!started_reg) begin
                                started_next     = 1'b1;
                                cycle_start_next = item_reg.now_ms;
                                last_rx_next     = item_reg.now_ms;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = item_reg.air_time_us;
                                div_req.divisor  = US_PER_MS;
                                state_next       = S_AIRDIV;
                            end
                        end
                    end
                    default: begin
                        cycle_start_next = item_reg.now_ms;
                        pending_next     = 1'b0;
                    end
                endcase
            end
            // re-anchor the cycle start near the expected cycle end
            S_POLL1: begin
                if (elapsed >= avg_cyc_reg - 32'(resync_reg)) begin
                    cycle_start_next = item_reg.now_ms;
                end
                state_next = S_POLL2;
            end
            // window, empty history or timeout
            S_POLL2: begin
                if ((elapsed > avg_air_reg + 32'(guard_reg)
                        && avg_cyc_reg - elapsed > 32'(guard_reg))
                    || fill_reg == '0
                    || item_reg.now_ms - last_rx_reg > {avg_cyc_reg[30:0], 1'b0}) begin
                    grant_next   = 1'b1;
                    pending_next = 1'b0;
                end
                state_next = S_DONE;
            end
            // push gap and padded airtime
            S_AIRDIV: begin
                if (div_rsp.done) begin
                    ram_we           = 1'b1;
                    wpos_next        = (wpos_reg == IDX_W'(HISTORY_DEPTH - 1)) ?
                                       '0 : wpos_reg + 1'b1;
                    if (fill_reg < CNT_W'(HISTORY_DEPTH)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    cycle_start_next = item_reg.now_ms;
                    last_rx_next     = item_reg.now_ms;
                    acc_cyc_next     = '0;
                    acc_air_next     = '0;
                    idx_next         = '0;
                    state_next       = S_RD;
                end
            end
            // walk the history, one entry per pass
            S_RD: begin
                ram_re     = 1'b1;
                state_next = S_DG;
            end
            S_DG: begin
                div_req.start    = 1'b1;
                div_req.dividend = ram_rdata[31:0];
                div_req.divisor  = DIV_W'(fill_reg);
                state_next       = S_WG;
            end
            S_WG: begin
                if (div_rsp.done) begin
                    acc_cyc_next     = acc_cyc_reg + div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = ram_rdata[63:32];
                    div_req.divisor  = DIV_W'(fill_reg);
                    state_next       = S_WA;
                end
            end
            S_WA: begin
                if (div_rsp.done) begin
                    acc_air_next = acc_air_reg + div_rsp.quotient;
                    if (CNT_W'(idx_reg) == fill_reg - 1'b1) begin
                        state_next = S_FIN;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_FIN: begin
                avg_cyc_next = acc_cyc_reg;
                avg_air_next = acc_air_reg;
                state_next   = S_DONE;
            end
            // hand the result to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cycle_start_reg <= '0;
            last_rx_reg     <= '0;
            pending_reg     <= 1'b0;
            started_reg     <= 1'b0;
            grant_reg       <= 1'b0;
            wpos_reg        <= '0;
            fill_reg        <= '0;
            avg_cyc_reg     <= '0;
            avg_air_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cycle_start_reg <= cycle_start_next;
            last_rx_reg     <= last_rx_next;
            pending_reg     <= pending_next;
            started_reg     <= started_next;
            grant_reg       <= grant_next;
            wpos_reg        <= wpos_next;
            fill_reg        <= fill_next;
            avg_cyc_reg     <= avg_cyc_next;
            avg_air_reg     <= avg_air_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_data;
        end
        acc_cyc_reg <= acc_cyc_next;
        acc_air_reg <= acc_air_next;
        idx_reg     <= idx_next;
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.grant        <= grant_reg;
            m_data_reg.tx_pending   <= pending_reg;
            m_data_reg.avg_cycle_ms <= avg_cyc_reg;
            m_data_reg.avg_air_ms   <= avg_air_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/tsg_ram.sv */
module tsg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/tsg_div.sv */
module tsg_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  tsg_pkg::div_req_t req,
    output tsg_pkg::div_rsp_t rsp
);
    import tsg_pkg::*;

    localparam int STEPS = 32 / DIV_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic [31:0]      quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        logic [DIV_W:0]  trial;
        logic [31:0]     q;
        logic [DIV_W-1:0] r;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {r, q[31]};
            q     = {q[30:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                trial = trial - {1'b0, dsr_reg};
                q[0]  = 1'b1;
            end
            r = trial[DIV_W-1:0];
        end
        quo_next = q;
        rem_next = r;
    end

    // control: busy while the quotient steps run, then a one-cycle done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* sv/tsg_checker.sv */
module tsg_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input tsg_pkg::in_t                s_data,
    input logic                        m_valid,
    input logic                        m_ready,
    input tsg_pkg::out_t               m_data,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [tsg_pkg::APB_AW-1:0]  paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready
);
    import tsg_pkg::*;

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a granted request is no longer pending
    a_grant_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.grant |-> !m_data.tx_pending)
        else $error("grant with request still pending");

    // one event in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed under stall");

endmodule

bind transmit_slot_gate_top tsg_checker u_tsg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
);
